[hdl/assert_macros.svh]
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define QDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qdc assertion failed");

// Expression must never be true outside reset.
`define QDC_NEVER(label, clk, rst_n, expr) \
    `QDC_ASSERT(label, clk, rst_n, !(expr))

`else

`define QDC_ASSERT(label, clk, rst_n, prop)
`define QDC_NEVER(label, clk, rst_n, expr)

`endif

`endif

[hdl/qdc_pkg.sv]
// Package: field masks, phase and result codes, and the decode result struct.
package qdc_pkg;

    // Word layout
    localparam logic [31:0] TYPE_MASK    = 32'h0700_0000;
    localparam logic [31:0] TYPE_HEADER  = 32'h0200_0000;
    localparam logic [31:0] TYPE_TRAILER = 32'h0400_0000;
    localparam int COUNT_LSB = 8;
    localparam int COUNT_W   = 6;
    localparam int VALUE_W   = 12;
    localparam int CHAN_LSB  = 16;
    localparam int CHAN_W    = 5;
    localparam int INDEX_W   = 16;
    localparam int KIND_W    = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_VALUE       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HEADER_ERR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRAILER_ERR = 2'd2;

    // Event phase
    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_DATA    = 2'd1,
        PH_TRAILER = 2'd2
    } phase_t;

    // One decoded word
    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [VALUE_W-1:0]   value;
        logic [INDEX_W-1:0]   index;
    } result_t;

endpackage

[hdl/qdc_decode.sv]
// Event phase machine and per-word decode logic.
`include "assert_macros.svh"

module qdc_decode
    import qdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [31:0]        word,
    input  logic               first,
    input  logic [INDEX_W-1:0] base_index,
    output result_t            result
);

    phase_t              phase_reg, phase_next;
    logic [COUNT_W-1:0]  left_reg, left_next;
    logic [COUNT_W-1:0]  count;
    logic [COUNT_W-1:0]  left_dec;
    logic [CHAN_W-1:0]   chan;

    assign count    = word[COUNT_LSB +: COUNT_W];
    assign chan     = word[CHAN_LSB +: CHAN_W];
    assign left_dec = left_reg - COUNT_W'(1);

    // State register, advanced once per decoded word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            left_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        left_next  = left_reg;
        result     = '0;
        if (first)
        begin
            // a flagged word is read as a header, abandoning any open event
            if ((word & TYPE_MASK) != TYPE_HEADER)
            begin
                phase_next   = PH_WAIT;
                left_next    = '0;
                result.valid = 1'b1;
                result.kind  = KIND_HEADER_ERR;
            end
            else
            begin
                left_next  = count;
                phase_next = (count == '0) ? PH_TRAILER : PH_DATA;
            end
        end
        else
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    left_next    = left_dec;
                    if (left_dec == '0)
                        phase_next = PH_TRAILER;
                    result.valid = 1'b1;
                    result.kind  = KIND_VALUE;
                    result.value = word[VALUE_W-1:0];
                    result.index = {{(INDEX_W-CHAN_W){1'b0}}, chan} + base_index;
                end
                PH_TRAILER:
                begin
                    phase_next = PH_WAIT;
                    left_next  = '0;
                    if ((word & TYPE_MASK) != TYPE_TRAILER)
                    begin
                        result.valid = 1'b1;
                        result.kind  = KIND_TRAILER_ERR;
                    end
                end
                default:
                begin
                    // waiting: stray words are dropped
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    // While reading data words the count is never exhausted
    `QDC_NEVER(a_data_count, clk, rst_n, phase_reg == PH_DATA && left_reg == '0)
    // Waiting and trailer phases hold no pending count
    `QDC_NEVER(a_idle_count, clk, rst_n, phase_reg != PH_DATA && left_reg != '0)

endmodule

[hdl/qdc_out_stage.sv]
// Result register between the decoder and the output channel.
module qdc_out_stage
    import qdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  result_t            result,
    output logic               advance,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  result_kind,
    output logic [VALUE_W-1:0] sample_value,
    output logic [INDEX_W-1:0] channel_index
);

    logic               vld_reg, vld_next;
    logic [KIND_W-1:0]  kind_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [INDEX_W-1:0] index_reg;

    // register free or emptied this cycle
    assign advance  = !vld_reg || out_ready;
    assign vld_next = advance ? (step && result.valid) : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // payload, loaded only with a real result
    always_ff @(posedge clk)
    begin
        if (advance && step && result.valid)
        begin
            kind_reg  <= result.kind;
            value_reg <= result.value;
            index_reg <= result.index;
        end
    end

    assign out_valid     = vld_reg;
    assign result_kind   = kind_reg;
    assign sample_value  = value_reg;
    assign channel_index = index_reg;

endmodule

[hdl/qdc_event_word_decoder.sv]
// Top level: input word register, decoder, result register and base index register.
// An accepted word waits in the input word register until the result register can advance.
// Throughput: one word per cycle; only a stalled output register holds up input.
// Words that cause no result still take a decode step.
// Reset (rst_n low, asynchronous): no word held, no result pending, waiting for
// a header, base index 0.
`include "assert_macros.svh"

module qdc_event_word_decoder
    import qdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [31:0]        data_word,
    input  logic               first_word,
    input  logic               cfg_wr_en,
    input  logic [INDEX_W-1:0] cfg_wr_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [KIND_W-1:0]  result_kind,
    output logic [VALUE_W-1:0] sample_value,
    output logic [INDEX_W-1:0] channel_index
);

    logic               in_vld_reg, in_vld_next;
    logic [31:0]        word_reg;
    logic               first_reg;
    logic [INDEX_W-1:0] base_reg;
    logic               advance;
    logic               step;
    logic               take;
    result_t            result;

    assign step     = in_vld_reg && advance;
    assign in_ready = !in_vld_reg || advance;
    assign take     = in_valid && in_ready;

    // Base index register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (cfg_wr_en)
            base_reg <= cfg_wr_data;
    end

    // Input word register
    assign in_vld_next = take ? 1'b1 : (step ? 1'b0 : in_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else
            in_vld_reg <= in_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg  <= data_word;
            first_reg <= first_word;
        end
    end

    qdc_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .word       (word_reg),
        .first      (first_reg),
        .base_index (base_reg),
        .result     (result)
    );

    qdc_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .result        (result),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .sample_value  (sample_value),
        .channel_index (channel_index)
    );

    // Input stalls only behind a stalled result
    `QDC_ASSERT(a_ready_stall, clk, rst_n, !in_ready |-> (out_valid && !out_ready))
    // Error results carry zero payload
    `QDC_ASSERT(a_err_zero, clk, rst_n,
        (out_valid && result_kind != KIND_VALUE) |-> (sample_value == '0 && channel_index == '0))
    // Only defined kinds leave the block
    `QDC_NEVER(a_kind_code, clk, rst_n,
        out_valid && result_kind != KIND_VALUE && result_kind != KIND_HEADER_ERR
        && result_kind != KIND_TRAILER_ERR)
    // A held word that is decoded leaves the input register unless refilled
    `QDC_ASSERT(a_step_drain, clk, rst_n, (step && !take) |=> !in_vld_reg)

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the event word decoder: directed and random event streams.
module tb;
    import qdc_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 60;
    localparam int PHASE_WORDS   = 170;
    localparam int STALL_LIMIT   = 2000;

    // One buffer word as offered to the block
    typedef struct packed {
        logic [31:0] word;
        logic        first;
    } buf_word_t;

    // One decoded result
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [INDEX_W-1:0] index;
    } decoded_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic [31:0]        data_word   = '0;
    logic               first_word  = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [INDEX_W-1:0] cfg_wr_data = '0;
    logic               out_ready   = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [KIND_W-1:0]  result_kind;
    logic [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0] channel_index;

    // Words waiting to be sent, results waiting to come out
    buf_word_t word_q[$];
    decoded_t  decoded_q[$];

    // Local copy of the decoder state and base index
    phase_t             model_phase = PH_WAIT;
    logic [COUNT_W-1:0] model_left  = '0;
    logic [INDEX_W-1:0] model_base  = '0;

    int  words_queued   = 0;
    int  words_offered  = 0;
    int  words_accepted = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  hold_left      = 0;
    int  hold_requests  = 0;
    int  hold_served    = 0;
    int  stall_cycles   = 0;
    int  failures       = 0;
    int  n_values       = 0;
    int  n_hdr_err      = 0;
    int  n_trl_err      = 0;
    int  n_settings     = 0;
    bit  steady         = 1'b0;

    qdc_event_word_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_word     (data_word),
        .first_word    (first_word),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .sample_value  (sample_value),
        .channel_index (channel_index)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Decode one accepted word into the expected results
    task automatic decode_word(input logic [31:0] w, input logic first);
        decoded_t           d;
        logic [INDEX_W-1:0] chan;
        d    = '0;
        chan = '0;
        if (first)
        begin
            if ((w & TYPE_MASK) != TYPE_HEADER)
            begin
                model_phase = PH_WAIT;
                model_left  = '0;
                d.kind      = KIND_HEADER_ERR;
                decoded_q.push_back(d);
            end
            else
            begin
                model_left  = w[COUNT_LSB +: COUNT_W];
                model_phase = (model_left == 0) ? PH_TRAILER : PH_DATA;
            end
        end
        else if (model_phase == PH_DATA)
        begin
            chan[CHAN_W-1:0] = w[CHAN_LSB +: CHAN_W];
            d.kind     = KIND_VALUE;
            d.value    = w[VALUE_W-1:0];
            d.index    = model_base + chan;
            model_left = model_left - 1'b1;
            if (model_left == 0)
                model_phase = PH_TRAILER;
            decoded_q.push_back(d);
        end
        else if (model_phase == PH_TRAILER)
        begin
            model_phase = PH_WAIT;
            model_left  = '0;
            if ((w & TYPE_MASK) != TYPE_TRAILER)
            begin
                d.kind = KIND_TRAILER_ERR;
                decoded_q.push_back(d);
            end
        end
        else
            model_phase = PH_WAIT;
    endtask

    task automatic note_mismatch(input string field, input int want, input int got);
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    // Check results first, then predict the word accepted at this edge
    always @(posedge clk)
    begin : check_and_predict
        decoded_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result kind %0h value %0h index %0h",
                             $time, result_kind, sample_value, channel_index);
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (result_kind !== want.kind)
                        note_mismatch("result_kind", want.kind, result_kind);
                    if (sample_value !== want.value)
                        note_mismatch("sample_value", want.value, sample_value);
                    if (channel_index !== want.index)
                        note_mismatch("channel_index", want.index, channel_index);
                    case (want.kind)
                        KIND_VALUE:      n_values++;
                        KIND_HEADER_ERR: n_hdr_err++;
                        default:         n_trl_err++;
                    endcase
                end
            end
            if (in_valid && in_ready)
            begin
                decode_word(data_word, first_word);
                words_accepted++;
            end
            // progress watchdog
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else if (word_q.size() != 0 || in_valid || decoded_q.size() != 0)
                stall_cycles++;
            else
                stall_cycles = 0;
        end
    end

    // Word driver: next word once the current one is taken, with random gaps
    always @(negedge clk)
    begin : drive_words
        buf_word_t nxt;
        if (rst_n && words_offered == words_accepted)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (word_q.size() == 0)
                in_valid <= 1'b0;
            else if (!steady && $urandom_range(0, 5) == 0)
            begin
                send_gap = $urandom_range(0, 2);
                in_valid <= 1'b0;
            end
            else
            begin
                nxt = word_q.pop_front();
                data_word  <= nxt.word;
                first_word <= nxt.first;
                in_valid   <= 1'b1;
                words_offered++;
            end
        end
    end

    // Result receiver: random stall bursts plus requested long hold-offs
    always @(negedge clk)
    begin : drive_ready
        if (hold_served != hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 4) == 0)
        begin
            recv_gap = $urandom_range(0, 2);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic push_word(input logic [31:0] w, input logic f);
        buf_word_t b;
        b.word  = w;
        b.first = f;
        word_q.push_back(b);
        words_queued++;
    endtask

    // Random 3-bit type code other than the given one
    function automatic logic [2:0] bad_type(input logic [2:0] good);
        logic [2:0] t;
        t = 3'($urandom_range(0, 6));
        if (t >= good)
            t = t + 3'd1;
        return t;
    endfunction

    // Mostly well-formed events, some with bad trailers, cut short, bad headers or strays
    task automatic push_random_event();
        int          pick;
        int          count;
        int          cut;
        logic [31:0] w;
        pick  = $urandom_range(0, 99);
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 63) : $urandom_range(0, 6);
        if ($urandom_range(0, 29) == 0)
            count = 63;
        if (pick < 88)
        begin
            w = $urandom();
            w[26:24] = TYPE_HEADER[26:24];
            w[COUNT_LSB +: COUNT_W] = count[COUNT_W-1:0];
            push_word(w, 1'b1);
            cut = (pick >= 80 && count > 0) ? $urandom_range(0, count - 1) : count;
            for (int i = 0; i < cut; i++)
                push_word($urandom(), 1'b0);
            if (cut == count)
            begin
                w = $urandom();
                w[26:24] = (pick >= 70) ? bad_type(TYPE_TRAILER[26:24]) : TYPE_TRAILER[26:24];
                push_word(w, 1'b0);
            end
        end
        else if (pick < 95)
        begin
            w = $urandom();
            w[26:24] = bad_type(TYPE_HEADER[26:24]);
            push_word(w, 1'b1);
            repeat ($urandom_range(0, 3))
                push_word($urandom(), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                push_word($urandom(), 1'b0);
        end
    endtask

    // Wait for all words sent and all results seen, then let the pipeline empty
    task automatic wait_drained();
        while (word_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_base(input logic [INDEX_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        model_base = v;
        n_settings++;
    endtask

    // Stimulus
    initial
    begin : stimulus
        logic [INDEX_W-1:0] bases [6];
        int                 target;
        bases[0] = 16'h0000;
        bases[1] = 16'($urandom_range(0, 65535));
        bases[2] = 16'hFFE0;
        bases[3] = 16'($urandom_range(0, 65535));
        bases[4] = 16'h8000;
        bases[5] = 16'($urandom_range(0, 65535));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: max base so channel 31 wraps
        write_base(16'hFFFF);
        push_word(32'hFFFF_FFFF, 1'b0);    // stray word while waiting
        push_word(32'h0200_0000, 1'b1);    // empty event, good trailer
        push_word(32'h0400_0000, 1'b0);
        push_word(32'hFAFF_C0FF, 1'b1);    // empty event, bad trailer
        push_word(32'hFBFF_FFFF, 1'b0);
        push_word(32'h0200_0200, 1'b1);    // two data words at the extremes
        push_word(32'h0000_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b0);
        push_word(32'hFCFF_FFFF, 1'b0);
        push_word(32'h0000_0100, 1'b1);    // bad header, then discarded words
        push_word(32'h0000_0ABC, 1'b0);
        push_word(32'h0400_0000, 1'b0);
        push_word(32'hFFFF_FFFF, 1'b1);    // bad header, all ones
        push_word(32'h0200_0300, 1'b1);    // header arrives mid-event
        push_word(32'h0015_0123, 1'b0);
        push_word(32'h0200_0100, 1'b1);
        push_word(32'h001F_0FFF, 1'b0);
        push_word(32'h0400_0000, 1'b0);
        push_word(32'h0200_0100, 1'b1);    // data then trailer of type 0
        push_word(32'h0001_0800, 1'b0);
        push_word(32'h0000_0000, 1'b0);
        push_word(32'h0200_0000, 1'b0);    // header-looking stray after trailer
        push_word(32'h0600_0000, 1'b1);    // bad header, type 6

        // Random phases, one base index setting each
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            write_base(bases[p]);
            if (p == 1)
                hold_requests++;    // long receiver hold while words keep coming
            if (p == 5)
                steady = 1'b1;      // no idling at the end
            target = words_queued + PHASE_WORDS;
            while (words_queued < target)
            begin
                push_random_event();
                // sender pause until every result is out
                if (p == 3 && words_queued >= target - PHASE_WORDS / 2 && hold_left == 0
                    && send_gap == 0 && words_queued < target - PHASE_WORDS / 2 + 8)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (decoded_q.size() != 0)
        begin
            failures++;
            $display("%0t: %0d results never arrived", $time, decoded_q.size());
        end
        $display("Run covered %0d words over %0d base index settings;", words_accepted,
                 n_settings);
        $display("checked %0d values, %0d header errors, %0d trailer errors, %0d failures.",
                 n_values, n_hdr_err, n_trl_err, failures);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Ends the run if nothing moves while work is outstanding
    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
